// File: rtl/sorted_priority_queue_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted priority queue unit
// Concurrent checks sampled on the rising clock, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted priority queue check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted priority queue check failed");

`endif

// File: rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Shared entry and control types, operation and status codes.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_RAISE  = 2'd1,
        OP_PEEK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DROPPED   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLACE
    } state_t;

    typedef struct packed {
        logic                     valid;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    // Broadcast to every cell in the chain
    typedef struct packed {
        logic                     place;
        logic                     remove;
        logic [ID_W-1:0]          id;
        logic signed [PRIO_W-1:0] prio;
    } cell_ctl_t;

endpackage

// File: rtl/spq_if.sv
// ---------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channels with valid/ready transfer.
// ---------------------------------------------------------------------------
interface spq_in_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              operation;
    logic [15:0]             item_id;
    logic signed [31:0]      value;

    modport source (output valid, operation, item_id, value, input ready);
    modport sink   (input valid, operation, item_id, value, output ready);
endinterface

interface spq_out_if;
    logic                    valid;
    logic                    ready;
    logic [15:0]             head_id;
    logic signed [31:0]      head_priority;
    logic                    queue_empty;
    logic [4:0]              entry_count;
    logic [1:0]              status;

    modport source (output valid, head_id, head_priority, queue_empty, entry_count, status,
                    input ready);
    modport sink   (input valid, head_id, head_priority, queue_empty, entry_count, status,
                    output ready);
endinterface

// File: rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts right on insert, left on removal.
// ---------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_ge,
    input  logic               left_found,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry,
    output spq_pkg::entry_t    entry_next,
    output logic               ge,
    output logic               found
);

    logic                             valid_reg;
    logic                             valid_next;
    logic [spq_pkg::ID_W-1:0]         id_reg;
    logic [spq_pkg::ID_W-1:0]         id_next;
    logic signed [spq_pkg::PRIO_W-1:0] prio_reg;
    logic signed [spq_pkg::PRIO_W-1:0] prio_next;
    logic                             match;

    assign entry = '{valid: valid_reg, id: id_reg, prio: prio_reg};

    // New entry belongs at or before this slot
    assign ge    = !valid_reg || (ctl.prio >= prio_reg);
    assign match = valid_reg && (id_reg == ctl.id);
    assign found = left_found || match;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (ctl.place && ge)
        begin
            if (left_ge)
            begin
                // advance the left neighbor into this slot
                valid_next = left_entry.valid;
                id_next    = left_entry.id;
                prio_next  = left_entry.prio;
            end
            else
            begin
                valid_next = 1'b1;
                id_next    = ctl.id;
                prio_next  = ctl.prio;
            end
        end
        else if (ctl.remove && found)
        begin
            // close the gap: pull the right neighbor in
            valid_next = right_entry.valid;
            id_next    = right_entry.id;
            prio_next  = right_entry.prio;
        end
    end

    assign entry_next = '{valid: valid_next, id: id_next, prio: prio_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

endmodule

// File: rtl/sorted_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// Sorted priority queue unit
// Chain of entry cells kept in descending priority order, with insert,
// priority increase and peek operations.
// ---------------------------------------------------------------------------
//  Channel | Dir | Signals                                               | Transfer
//  req     | in  | operation, item_id, value                             | valid & ready
//  rsp     | out | head_id, head_priority, queue_empty, entry_count,     | valid & ready
//          |     | status                                                |
//
//  Insert and peek finish from idle; an increase removes, then reinserts
//  in S_PLACE, and ends at once if the id is absent. The two steps set the rate.
//  Reset clears all cell valid bits and the count; payload is not reset.
//  A request is taken only while the control is idle and the response
//  register is empty or drains in the same cycle, so a stalled rsp holds req.
// ---------------------------------------------------------------------------
`include "sorted_priority_queue_unit_assert.svh"

module sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    spq_in_if.sink     req,
    spq_out_if.source  rsp
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Cell chain links
    spq_pkg::entry_t    cell_cur   [QUEUE_DEPTH];
    spq_pkg::entry_t    cell_nxt   [QUEUE_DEPTH];
    spq_pkg::entry_t    link_left  [QUEUE_DEPTH];
    spq_pkg::entry_t    link_right [QUEUE_DEPTH];
    logic               cell_ge    [QUEUE_DEPTH];
    logic               cell_found [QUEUE_DEPTH];
    logic               link_ge    [QUEUE_DEPTH];
    logic               link_found [QUEUE_DEPTH];
    spq_pkg::cell_ctl_t ctl;

    // Control
    spq_pkg::state_t          state_reg;
    spq_pkg::state_t          state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [spq_pkg::ID_W-1:0] id_reg;
    logic [spq_pkg::ID_W-1:0] id_next;
    logic signed [spq_pkg::PRIO_W-1:0] sum_reg;
    logic signed [spq_pkg::PRIO_W-1:0] sum_next;

    // Response register
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [15:0]              head_id_reg;
    logic signed [31:0]       head_prio_reg;
    logic                     empty_reg;
    logic [4:0]               count_out_reg;
    spq_pkg::status_t         status_reg;

    logic                     take;
    logic                     load_out;
    spq_pkg::status_t         status_new;
    logic                     full;
    logic signed [spq_pkg::PRIO_W-1:0] hit_prio;
    logic signed [spq_pkg::PRIO_W:0]   wide_sum;

    // -----------------------------------------------------------------------
    // Cell chain
    // -----------------------------------------------------------------------
    for (genvar k = 0; k < QUEUE_DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign link_left[k]  = '0;
            assign link_ge[k]    = 1'b0;
            assign link_found[k] = 1'b0;
        end
        else
        begin : g_inner
            assign link_left[k]  = cell_cur[k-1];
            assign link_ge[k]    = cell_ge[k-1];
            assign link_found[k] = cell_found[k-1];
        end

        if (k == QUEUE_DEPTH - 1)
        begin : g_tail
            assign link_right[k] = '0;
        end
        else
        begin : g_body
            assign link_right[k] = cell_cur[k+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_entry  (link_left[k]),
            .left_ge     (link_ge[k]),
            .left_found  (link_found[k]),
            .right_entry (link_right[k]),
            .entry       (cell_cur[k]),
            .entry_next  (cell_nxt[k]),
            .ge          (cell_ge[k]),
            .found       (cell_found[k])
        );
    end

    // Priority of the first matching cell: the first-match flag is one-hot
    always_comb
    begin
        hit_prio = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++)
        begin
            if (cell_found[k] && !link_found[k])
                hit_prio = hit_prio | cell_cur[k].prio;
        end
    end

    // Saturating add of the delta
    assign wide_sum = {hit_prio[spq_pkg::PRIO_W-1], hit_prio}
                    + {req.value[spq_pkg::PRIO_W-1], req.value};

    always_comb
    begin
        if (wide_sum[spq_pkg::PRIO_W] != wide_sum[spq_pkg::PRIO_W-1])
            sum_next = wide_sum[spq_pkg::PRIO_W]
                     ? {1'b1, {(spq_pkg::PRIO_W-1){1'b0}}}
                     : {1'b0, {(spq_pkg::PRIO_W-1){1'b1}}};
        else
            sum_next = wide_sum[spq_pkg::PRIO_W-1:0];
    end

    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));

    // -----------------------------------------------------------------------
    // Control: next state, cell commands, count and response load
    // -----------------------------------------------------------------------
    assign req.ready = (state_reg == spq_pkg::S_IDLE) && (!out_valid_reg || rsp.ready);
    assign take      = req.valid && req.ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        id_next    = id_reg;
        ctl        = '0;
        load_out   = 1'b0;
        status_new = spq_pkg::ST_OK;
        case (state_reg)
            spq_pkg::S_IDLE:
            begin
                if (take)
                begin
                    case (spq_pkg::op_t'(req.operation))
                        spq_pkg::OP_INSERT:
                        begin
                            ctl.place = 1'b1;
                            ctl.id    = req.item_id;
                            ctl.prio  = req.value;
                            load_out  = 1'b1;
                            if (full)
                                status_new = spq_pkg::ST_DROPPED;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        spq_pkg::OP_RAISE:
                        begin
                            ctl.id = req.item_id;
                            if (cell_found[QUEUE_DEPTH-1])
                            begin
                                // drop the entry from the chain, reinsert next cycle
                                ctl.remove = 1'b1;
                                count_next = count_reg - 1'b1;
                                id_next    = req.item_id;
                                state_next = spq_pkg::S_PLACE;
                            end
                            else
                            begin
                                load_out   = 1'b1;
                                status_new = spq_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            spq_pkg::S_PLACE:
            begin
                ctl.place  = 1'b1;
                ctl.id     = id_reg;
                ctl.prio   = sum_reg;
                count_next = count_reg + 1'b1;
                load_out   = 1'b1;
                state_next = spq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = spq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the raised entry between removal and reinsertion
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        sum_reg <= sum_next;
    end

    // Capture the head as it will stand after this cycle's update
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            head_id_reg   <= cell_nxt[0].valid ? cell_nxt[0].id : '0;
            head_prio_reg <= cell_nxt[0].valid ? cell_nxt[0].prio : '0;
            empty_reg     <= !cell_nxt[0].valid;
            count_out_reg <= 5'(count_next);
            status_reg    <= status_new;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.head_id       = head_id_reg;
    assign rsp.head_priority = head_prio_reg;
    assign rsp.queue_empty   = empty_reg;
    assign rsp.entry_count   = count_out_reg;
    assign rsp.status        = status_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `SPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `SPQ_ASSERT_IMP(a_head_vs_count, clk, rst_n, 1'b1, cell_cur[0].valid == (count_reg != '0))
    `SPQ_ASSERT_NXT(a_place_follows, clk, rst_n, state_reg == spq_pkg::S_PLACE, state_reg == spq_pkg::S_IDLE && out_valid_reg)

endmodule

// File: tb/sv/sorted_priority_queue_unit_tb.sv
// ---------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Walks a short table of directed requests, then three random phases with
// shifting idle patterns on both channels. Every response is checked field
// by field against an in-order store of results, fixed in the directed table
// or worked out by a local model of the queue.
// ---------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD_CYCLES = 400;

    // Encoding that the block must treat as a peek
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [31:0] PRIO_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [15:0]        head_id;
        logic signed [31:0] head_priority;
        logic               queue_empty;
        logic [4:0]         entry_count;
        spq_pkg::status_t   status;
    } queue_result_t;

    typedef struct {
        logic [1:0]         op;
        logic [15:0]        id;
        logic signed [31:0] value;
        bit                 has_fixed;
        queue_result_t      fixed_res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    sorted_priority_queue_unit #(
        .QUEUE_DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Local copy of the queue contents, slot 0 is the head
    logic [15:0]        held_ids   [DEPTH];
    logic signed [31:0] held_prios [DEPTH];
    int                 held_count;

    queue_result_t pending_results [$];
    stim_row_t     directed_rows [$];

    int error_count;
    int req_idle_pct;
    int rsp_idle_pct;
    int long_hold_request;

    // -----------------------------------------------------------------------
    // Clock and reset
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // -----------------------------------------------------------------------
    // Queue model
    // -----------------------------------------------------------------------

    // Place an entry ahead of the first one with equal or lower priority;
    // when full, the last slot falls off (possibly the new entry itself).
    function automatic spq_pkg::status_t place_held_entry(logic [15:0] id,
                                                          logic signed [31:0] prio);
        int               pos;
        int               last;
        int               k;
        spq_pkg::status_t st;
        pos = held_count;
        st  = spq_pkg::ST_OK;
        for (k = 0; k < held_count; k++)
        begin
            if (prio >= held_prios[k])
            begin
                pos = k;
                break;
            end
        end
        if (held_count >= DEPTH)
        begin
            st = spq_pkg::ST_DROPPED;
            if (pos >= DEPTH)
                return st;
            last = DEPTH - 1;
        end
        else
        begin
            last = held_count;
            held_count++;
        end
        for (k = last; k > pos; k--)
        begin
            held_ids[k]   = held_ids[k-1];
            held_prios[k] = held_prios[k-1];
        end
        held_ids[pos]   = id;
        held_prios[pos] = prio;
        return st;
    endfunction

    // Pull the first matching entry, add the delta with saturation, reinsert
    function automatic spq_pkg::status_t raise_held_entry(logic [15:0] id,
                                                          logic signed [31:0] delta);
        int      found;
        int      k;
        longint  sum;
        found = held_count;
        for (k = 0; k < held_count; k++)
        begin
            if (held_ids[k] == id)
            begin
                found = k;
                break;
            end
        end
        if (found >= held_count)
            return spq_pkg::ST_NOT_FOUND;
        sum = longint'(held_prios[found]) + longint'(delta);
        if (sum > longint'(PRIO_MAX))
            sum = longint'(PRIO_MAX);
        if (sum < longint'(PRIO_MIN))
            sum = longint'(PRIO_MIN);
        for (k = found; k + 1 < held_count; k++)
        begin
            held_ids[k]   = held_ids[k+1];
            held_prios[k] = held_prios[k+1];
        end
        held_count--;
        void'(place_held_entry(id, 32'(sum)));
        return spq_pkg::ST_OK;
    endfunction

    function automatic queue_result_t apply_queue_op(logic [1:0] op, logic [15:0] id,
                                                     logic signed [31:0] value);
        queue_result_t res;
        res.status = spq_pkg::ST_OK;
        case (op)
            spq_pkg::OP_INSERT: res.status = place_held_entry(id, value);
            spq_pkg::OP_RAISE:  res.status = raise_held_entry(id, value);
            default:            res.status = spq_pkg::ST_OK;
        endcase
        if (held_count > 0)
        begin
            res.head_id       = held_ids[0];
            res.head_priority = held_prios[0];
            res.queue_empty   = 1'b0;
        end
        else
        begin
            res.head_id       = '0;
            res.head_priority = '0;
            res.queue_empty   = 1'b1;
        end
        res.entry_count = 5'(held_count);
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic void add_row(logic [1:0] op, logic [15:0] id, logic signed [31:0] value,
                                    bit has_fixed, queue_result_t fixed_res);
        stim_row_t row;
        row.op        = op;
        row.id        = id;
        row.value     = value;
        row.has_fixed = has_fixed;
        row.fixed_res = fixed_res;
        directed_rows.push_back(row);
    endfunction

    // Lean on the extremes and on small deltas so entries actually reorder
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0:       return PRIO_MAX;
            1:       return PRIO_MIN;
            2:       return 32'($signed($urandom_range(32))) - 32'sd16;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Offer one request, hold it until the transfer, then record the outcome
    task automatic send_request(logic [1:0] op, logic [15:0] id, logic signed [31:0] value,
                                bit has_fixed, queue_result_t fixed_res);
        queue_result_t predicted;
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.item_id   <= id;
        req_if.value     <= value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = apply_queue_op(op, id, value);
        pending_results.push_back(has_fixed ? fixed_res : predicted);
    endtask

    // Drop valid and hold off until every outstanding response has arrived
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic: raises mostly aim at held ids; other ids come
    // half from a small pool so duplicates appear, half from the full range.
    task automatic run_random_phase(int n_items);
        int          n;
        int          pick;
        logic [1:0]  op;
        logic [15:0] id;
        for (n = 0; n < n_items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                op = spq_pkg::OP_INSERT;
            else if (pick < 85)
                op = spq_pkg::OP_RAISE;
            else if (pick < 95)
                op = spq_pkg::OP_PEEK;
            else
                op = OP_UNUSED;
            if (op == spq_pkg::OP_RAISE && held_count > 0 && $urandom_range(9) < 8)
                id = held_ids[$urandom_range(held_count - 1)];
            else if ($urandom_range(1) == 1)
                id = 16'($urandom_range(15));
            else
                id = 16'($urandom());
            send_request(op, id, pick_value(), 1'b0, '0);
        end
    endtask

    // -----------------------------------------------------------------------
    // Response side: random stalls, plus a long hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_request > 0)
            begin
                hold_left = long_hold_request;
                long_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Response checker: compare each transfer with the oldest expectation
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: response with nothing expected, actual head_id %h status %0d",
                         $time, rsp_if.head_id, rsp_if.status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_if.head_id !== want.head_id)
                begin
                    $display("%0t: head_id expected %h actual %h",
                             $time, want.head_id, rsp_if.head_id);
                    error_count++;
                end
                if (rsp_if.head_priority !== want.head_priority)
                begin
                    $display("%0t: head_priority expected %0d actual %0d",
                             $time, want.head_priority, rsp_if.head_priority);
                    error_count++;
                end
                if (rsp_if.queue_empty !== want.queue_empty)
                begin
                    $display("%0t: queue_empty expected %b actual %b",
                             $time, want.queue_empty, rsp_if.queue_empty);
                    error_count++;
                end
                if (rsp_if.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, rsp_if.entry_count);
                    error_count++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_if.status);
                    error_count++;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: count cycles without any transfer on either channel
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        int quiet_cycles;
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, pending_results.size());
            $display("sorted_priority_queue_unit regression: fail");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int k;
        error_count       = 0;
        req_idle_pct      = 16;
        rsp_idle_pct      = 52;
        long_hold_request = 0;
        held_count        = 0;
        for (k = 0; k < DEPTH; k++)
        begin
            held_ids[k]   = '0;
            held_prios[k] = '0;
        end
        rst_n            = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = spq_pkg::OP_PEEK;
        req_if.item_id   = '0;
        req_if.value     = '0;

        // Empty queue: peek, raise of an absent id, unused opcode
        add_row(spq_pkg::OP_PEEK,  16'h0000, 32'sd0, 1'b1,
                '{16'h0000, 32'sd0, 1'b1, 5'd0, spq_pkg::ST_OK});
        add_row(spq_pkg::OP_RAISE, 16'h0005, 32'sd7, 1'b1,
                '{16'h0000, 32'sd0, 1'b1, 5'd0, spq_pkg::ST_NOT_FOUND});
        add_row(OP_UNUSED, 16'hFFFF, PRIO_MIN, 1'b1,
                '{16'h0000, 32'sd0, 1'b1, 5'd0, spq_pkg::ST_OK});
        // Field extremes, and newest-first among equal priorities
        add_row(spq_pkg::OP_INSERT, 16'hFFFF, PRIO_MAX, 1'b1,
                '{16'hFFFF, PRIO_MAX, 1'b0, 5'd1, spq_pkg::ST_OK});
        add_row(spq_pkg::OP_INSERT, 16'h0000, PRIO_MIN, 1'b1,
                '{16'hFFFF, PRIO_MAX, 1'b0, 5'd2, spq_pkg::ST_OK});
        add_row(spq_pkg::OP_INSERT, 16'h1234, PRIO_MAX, 1'b1,
                '{16'h1234, PRIO_MAX, 1'b0, 5'd3, spq_pkg::ST_OK});
        // Saturation at both ends, a negative delta moving an entry down
        add_row(spq_pkg::OP_RAISE, 16'h1234, 32'sd5, 1'b1,
                '{16'h1234, PRIO_MAX, 1'b0, 5'd3, spq_pkg::ST_OK});
        add_row(spq_pkg::OP_RAISE, 16'h0000, PRIO_MIN, 1'b0, '0);
        add_row(spq_pkg::OP_RAISE, 16'hFFFF, -32'sd1, 1'b0, '0);
        add_row(spq_pkg::OP_RAISE, 16'h0000, PRIO_MAX, 1'b0, '0);
        // Fill to capacity, with a duplicate id further down
        for (k = 0; k < 12; k++)
            add_row(spq_pkg::OP_INSERT, 16'h0100 + 16'(k), 32'(k * 1000 - 6000), 1'b0, '0);
        add_row(spq_pkg::OP_INSERT, 16'hFFFF, 32'sd0, 1'b0, '0);
        // Full queue: the new entry is the lowest and falls off itself,
        // then a new head pushes the last slot out
        add_row(spq_pkg::OP_INSERT, 16'h00AA, PRIO_MIN, 1'b1,
                '{16'h1234, PRIO_MAX, 1'b0, 5'd16, spq_pkg::ST_DROPPED});
        add_row(spq_pkg::OP_INSERT, 16'hABCD, PRIO_MAX, 1'b1,
                '{16'hABCD, PRIO_MAX, 1'b0, 5'd16, spq_pkg::ST_DROPPED});
        // Raise hits the first of two matching ids
        add_row(spq_pkg::OP_RAISE, 16'hFFFF, 32'sd1, 1'b0, '0);
        add_row(spq_pkg::OP_RAISE, 16'h7777, 32'sd9, 1'b1,
                '{16'hFFFF, PRIO_MAX, 1'b0, 5'd16, spq_pkg::ST_NOT_FOUND});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender idles lightly, receiver heavily
        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].id, directed_rows[i].value,
                         directed_rows[i].has_fixed, directed_rows[i].fixed_res);

        // Hold the response side for a long stretch while requests keep
        // coming, so the block backs up and stalls its input
        long_hold_request = LONG_HOLD_CYCLES;
        run_random_phase(40);
        wait_for_drain();
        run_random_phase(310);
        wait_for_drain();

        // Phase two: roles swapped
        req_idle_pct = 52;
        rsp_idle_pct = 16;
        run_random_phase(350);
        wait_for_drain();

        // Phase three: back to back
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_random_phase(350);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sorted_priority_queue_unit regression: pass");
        else
            $display("sorted_priority_queue_unit regression: fail");
        $finish;
    end

endmodule
